[hw/rtl/scca_pkg.sv]
// ----------------------------------------------------------------------------
// scca_pkg
// Shared types, codes and sizing functions of the surface cache allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scca_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam int MEM_W   = 23;
    localparam int REQ_W   = 3;
    localparam int SIDE_W  = 8;
    localparam int OWNER_W = 16;
    localparam int TEX_W   = 8;
    localparam int IDX_W   = 6;
    localparam int KIND_W  = 3;
    localparam int DIM_W   = 9;
    localparam int AGE_W   = 2;
    localparam int SZ_W    = 2 * DIM_W;
    localparam int CFG_W   = 2;
    localparam int ATTR_W  = OWNER_W + TEX_W + 2 * DIM_W;

    localparam logic [MEM_W-1:0] CAP_RESET   = 23'd2097152;
    localparam logic [MEM_W-1:0] LIMIT_RESET = 23'd1572864;
    localparam logic [MEM_W-1:0] MEM_MAX     = 23'h7FFFFF;

    localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_TEX = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOUCH     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_NEW_FRAME = 3'd5;

    localparam logic [KIND_W-1:0] RES_EVICT    = 3'd0;
    localparam logic [KIND_W-1:0] RES_ALLOC_OK = 3'd1;
    localparam logic [KIND_W-1:0] RES_FAIL     = 3'd2;
    localparam logic [KIND_W-1:0] RES_DONE     = 3'd3;
    localparam logic [KIND_W-1:0] RES_ERROR    = 3'd4;

    localparam logic [CFG_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_W-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ROUNDING = 2'd2;

    localparam logic [AGE_W-1:0] AGE_FRESH = 2'd3;
    localparam logic [AGE_W-1:0] AGE_LATE  = 2'd2;
    localparam logic [AGE_W-1:0] AGE_TOUCH = 2'd1;

    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_HAND = 2'd1;
    localparam logic [1:0] CUR_IDX  = 2'd2;
    localparam logic [1:0] CUR_ONE  = 2'd3;

    typedef struct packed {
        logic              latch_req;
        logic [1:0]        cur_op;
        logic              cur_inc;
        logic              rd;
        logic              link_rd;
        logic              pop;
        logic              bump;
        logic              take_cur;
        logic              age_dec;
        logic              age_touch;
        logic              free_op;
        logic              push;
        logic              hand_adv;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              calc_size;
        logic              commit;
        logic              frame_clr;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             out_free;
        logic             frame_over;
        logic             fh_nz;
        logic             hw_full;
        logic             cur_valid;
        logic             cur_last;
        logic             age_zero;
        logic             tex_match;
        logic             idx_zero;
        logic             idx_in_range;
        logic             cnt_last;
        logic             fit_over;
        logic             fit_ge;
    } dp_stat_t;

    function automatic logic [DIM_W-1:0] round_pow2(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v <= 9'd8)        r = 9'd8;
        else if (v <= 9'd16)  r = 9'd16;
        else if (v <= 9'd32)  r = 9'd32;
        else if (v <= 9'd64)  r = 9'd64;
        else if (v <= 9'd128) r = 9'd128;
        else if (v <= 9'd256) r = 9'd256;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] round_height(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v <= 9'd8)        r = v;
        else if (v <= 9'd12)  r = 9'd12;
        else if (v <= 9'd16)  r = 9'd16;
        else if (v <= 9'd24)  r = 9'd24;
        else if (v <= 9'd32)  r = 9'd32;
        else if (v <= 9'd48)  r = 9'd48;
        else if (v <= 9'd64)  r = 9'd64;
        else if (v <= 9'd96)  r = 9'd96;
        else if (v <= 9'd128) r = 9'd128;
        else if (v <= 9'd192) r = 9'd192;
        else if (v <= 9'd256) r = 9'd256;
        else if (v <= 9'd384) r = 9'd384;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/scca_ifs.sv]
// ----------------------------------------------------------------------------
// scca request and result channels
// Valid/ready channels carrying one request or one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface scca_req_if;
    logic                          valid;
    logic                          ready;
    logic [scca_pkg::REQ_W-1:0]    req_type;
    logic [scca_pkg::SIDE_W-1:0]   surf_width;
    logic [scca_pkg::SIDE_W-1:0]   surf_height;
    logic [scca_pkg::OWNER_W-1:0]  owner_handle;
    logic [scca_pkg::TEX_W-1:0]    texture_tag;
    logic [scca_pkg::IDX_W-1:0]    entry_index;

    modport source (output valid, req_type, surf_width, surf_height, owner_handle,
                    texture_tag, entry_index, input ready);
    modport sink (input valid, req_type, surf_width, surf_height, owner_handle,
                  texture_tag, entry_index, output ready);
endinterface

interface scca_res_if;
    logic                          valid;
    logic                          ready;
    logic [scca_pkg::KIND_W-1:0]   result_kind;
    logic [scca_pkg::IDX_W-1:0]    result_entry;
    logic [scca_pkg::OWNER_W-1:0]  result_owner;
    logic [scca_pkg::DIM_W-1:0]    alloc_width;
    logic [scca_pkg::DIM_W-1:0]    alloc_height;
    logic                          last_result;

    modport source (output valid, result_kind, result_entry, result_owner, alloc_width,
                    alloc_height, last_result, input ready);
    modport sink (input valid, result_kind, result_entry, result_owner, alloc_width,
                  alloc_height, last_result, output ready);
endinterface

`default_nettype wire

[hw/rtl/scca_ram.sv]
// ----------------------------------------------------------------------------
// scca_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/scca_datapath.sv]
// ----------------------------------------------------------------------------
// scca_datapath
// Entry tables, free list, clock hand, memory counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scca_datapath #(
    parameter int ENTRIES = scca_pkg::DEF_ENTRIES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [scca_pkg::CFG_W-1:0]     cfg_index,
    input  wire logic [scca_pkg::MEM_W-1:0]     cfg_data,
    input  wire logic [scca_pkg::REQ_W-1:0]     req_type,
    input  wire logic [scca_pkg::SIDE_W-1:0]    surf_width,
    input  wire logic [scca_pkg::SIDE_W-1:0]    surf_height,
    input  wire logic [scca_pkg::OWNER_W-1:0]   owner_handle,
    input  wire logic [scca_pkg::TEX_W-1:0]     texture_tag,
    input  wire logic [scca_pkg::IDX_W-1:0]     entry_index,
    input  wire scca_pkg::dp_cmd_t              cmd,
    output scca_pkg::dp_stat_t                  stat,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [scca_pkg::KIND_W-1:0]         result_kind,
    output logic [scca_pkg::IDX_W-1:0]          result_entry,
    output logic [scca_pkg::OWNER_W-1:0]        result_owner,
    output logic [scca_pkg::DIM_W-1:0]          alloc_width,
    output logic [scca_pkg::DIM_W-1:0]          alloc_height,
    output logic                                last_result
);

    import scca_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(2 * ENTRIES + 1);

    logic [MEM_W-1:0]   cap_reg, cap_next;
    logic [MEM_W-1:0]   limit_reg, limit_next;
    logic               mode_reg, mode_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]      free_head_reg, free_head_next;
    logic [IW-1:0]      hw_reg, hw_next;
    logic [MEM_W-1:0]   used_reg, used_next;
    logic [MEM_W-1:0]   frame_reg, frame_next;
    logic [IW-1:0]      hand_reg, hand_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      n_reg, n_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;

    logic [REQ_W-1:0]   req_type_reg;
    logic [SIDE_W-1:0]  req_w_reg, req_h_reg;
    logic [OWNER_W-1:0] req_owner_reg;
    logic [TEX_W-1:0]   req_tex_reg;
    logic [IDX_W-1:0]   req_idx_reg;
    logic [DIM_W-1:0]   x_reg, y_reg;
    logic [SZ_W-1:0]    sz_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [IDX_W-1:0]   entry_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [DIM_W-1:0]   w_out_reg, h_out_reg;
    logic               last_reg;

    logic [ATTR_W-1:0]  attr_rdata;
    logic [AGE_W-1:0]   age_rdata;
    logic [IW-1:0]      link_rdata;
    logic [DIM_W-1:0]   rd_w, rd_h;
    logic [TEX_W-1:0]   rd_tex;
    logic [OWNER_W-1:0] rd_owner;

    logic [DIM_W-1:0]   pad_w, pad_h, rnd_w, rnd_h, mul_a, mul_b;
    logic [SZ_W-1:0]    product;
    logic [MEM_W-1:0]   prod_ext, used_sub, used_add, frame_add;
    logic [MEM_W:0]     used_sum, frame_sum, fit_sum;
    logic [IW-1:0]      hand_step;
    logic               age_we;
    logic [IW-1:0]      age_waddr;
    logic [AGE_W-1:0]   age_wdata;

    assign rd_w     = attr_rdata[DIM_W-1:0];
    assign rd_h     = attr_rdata[2*DIM_W-1:DIM_W];
    assign rd_tex   = attr_rdata[2*DIM_W+TEX_W-1:2*DIM_W];
    assign rd_owner = attr_rdata[ATTR_W-1:2*DIM_W+TEX_W];

    assign pad_w = {1'b0, req_w_reg} + 9'd4;
    assign pad_h = {1'b0, req_h_reg} + 9'd4;
    assign rnd_w = mode_reg ? pad_w : round_pow2(pad_w);
    assign rnd_h = mode_reg ? round_height(pad_h) : round_pow2(pad_h);

    assign mul_a   = cmd.calc_size ? rnd_w : rd_w;
    assign mul_b   = cmd.calc_size ? rnd_h : rd_h;
    assign product = mul_a * mul_b;

    assign prod_ext  = {{(MEM_W-SZ_W){1'b0}}, product};
    assign used_sub  = (used_reg > prod_ext) ? used_reg - prod_ext : '0;
    assign used_sum  = {1'b0, used_reg} + {{(MEM_W+1-SZ_W){1'b0}}, sz_reg};
    assign frame_sum = {1'b0, frame_reg} + {{(MEM_W+1-SZ_W){1'b0}}, sz_reg};
    assign used_add  = used_sum[MEM_W] ? MEM_MAX : used_sum[MEM_W-1:0];
    assign frame_add = frame_sum[MEM_W] ? MEM_MAX : frame_sum[MEM_W-1:0];
    assign fit_sum   = used_sum;

    assign hand_step = (hand_reg == IW'(ENTRIES - 1)) ? IW'(1) : hand_reg + IW'(1);

    always_comb
    begin
        stat.req_type     = req_type_reg;
        stat.out_free     = !res_valid_reg || res_ready;
        stat.frame_over   = frame_reg > limit_reg;
        stat.fh_nz        = free_head_reg != '0;
        stat.hw_full      = hw_reg == IW'(ENTRIES - 1);
        stat.cur_valid    = valid_reg[cur_reg];
        stat.cur_last     = cur_reg == IW'(ENTRIES - 1);
        stat.age_zero     = age_rdata == '0;
        stat.tex_match    = rd_tex == req_tex_reg;
        stat.idx_zero     = req_idx_reg == '0;
        stat.idx_in_range = {26'd0, req_idx_reg} < 32'(ENTRIES);
        stat.cnt_last     = cnt_reg >= CW'(2 * ENTRIES);
        stat.fit_over     = fit_sum > {1'b0, cap_reg};
        stat.fit_ge       = fit_sum >= {1'b0, cap_reg};
    end

    always_comb
    begin
        cap_next       = cap_reg;
        limit_next     = limit_reg;
        mode_next      = mode_reg;
        valid_next     = valid_reg;
        free_head_next = free_head_reg;
        hw_next        = hw_reg;
        used_next      = used_reg;
        frame_next     = frame_reg;
        hand_next      = hand_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_next   = cfg_data;
                CFG_LIMIT:    limit_next = cfg_data;
                CFG_ROUNDING: mode_next  = cfg_data[0];
                default:      ;
            endcase
        end

        unique case (cmd.cur_op)
            CUR_HAND: cur_next = hand_reg;
            CUR_IDX:  cur_next = IW'(req_idx_reg);
            CUR_ONE:  cur_next = IW'(1);
            default:  ;
        endcase
        if (cmd.cur_inc)
        begin
            cur_next = cur_reg + IW'(1);
        end
        if (cmd.hand_adv)
        begin
            hand_next = hand_step;
            cur_next  = hand_step;
        end

        if (cmd.pop)
        begin
            n_next         = free_head_reg;
            free_head_next = link_rdata;
        end
        if (cmd.bump)
        begin
            n_next  = hw_reg + IW'(1);
            hw_next = hw_reg + IW'(1);
        end
        if (cmd.take_cur)
        begin
            n_next = cur_reg;
        end
        if (cmd.free_op)
        begin
            valid_next[cur_reg] = 1'b0;
            used_next           = used_sub;
        end
        if (cmd.push)
        begin
            free_head_next = cur_reg;
        end
        if (cmd.commit)
        begin
            valid_next[n_reg] = 1'b1;
            used_next         = used_add;
            frame_next        = frame_add;
        end
        if (cmd.frame_clr)
        begin
            frame_next = '0;
        end
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            limit_reg     <= LIMIT_RESET;
            mode_reg      <= 1'b1;
            valid_reg     <= '0;
            free_head_reg <= '0;
            hw_reg        <= '0;
            used_reg      <= '0;
            frame_reg     <= '0;
            hand_reg      <= IW'(1);
            cur_reg       <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            limit_reg     <= limit_next;
            mode_reg      <= mode_next;
            valid_reg     <= valid_next;
            free_head_reg <= free_head_next;
            hw_reg        <= hw_next;
            used_reg      <= used_next;
            frame_reg     <= frame_next;
            hand_reg      <= hand_next;
            cur_reg       <= cur_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_type_reg  <= req_type;
            req_w_reg     <= surf_width;
            req_h_reg     <= surf_height;
            req_owner_reg <= owner_handle;
            req_tex_reg   <= texture_tag;
            req_idx_reg   <= entry_index;
        end
        if (cmd.calc_size)
        begin
            x_reg  <= rnd_w;
            y_reg  <= rnd_h;
            sz_reg <= product;
        end
        if (cmd.emit)
        begin
            kind_reg  <= cmd.kind;
            last_reg  <= cmd.kind != RES_EVICT;
            entry_reg <= (cmd.kind == RES_EVICT) ? IDX_W'(cur_reg) :
                         (cmd.kind == RES_ALLOC_OK) ? IDX_W'(n_reg) : '0;
            owner_reg <= (cmd.kind == RES_EVICT) ? rd_owner : '0;
            w_out_reg <= (cmd.kind == RES_ALLOC_OK) ? x_reg : '0;
            h_out_reg <= (cmd.kind == RES_ALLOC_OK) ? y_reg : '0;
        end
    end

    assign age_we    = cmd.age_dec || cmd.age_touch || cmd.commit;
    assign age_waddr = cmd.commit ? n_reg : cur_reg;
    assign age_wdata = cmd.commit ? ((frame_add < limit_reg) ? AGE_FRESH : AGE_LATE) :
                       cmd.age_touch ? AGE_TOUCH : age_rdata - AGE_W'(1);

    scca_ram #(.WIDTH(ATTR_W), .DEPTH(ENTRIES)) u_attr_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (n_reg),
        .wdata ({req_owner_reg, req_tex_reg, y_reg, x_reg}),
        .re    (cmd.rd),
        .raddr (cur_reg),
        .rdata (attr_rdata)
    );

    scca_ram #(.WIDTH(AGE_W), .DEPTH(ENTRIES)) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .re    (cmd.rd),
        .raddr (cur_reg),
        .rdata (age_rdata)
    );

    scca_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (cur_reg),
        .wdata (free_head_reg),
        .re    (cmd.link_rd),
        .raddr (free_head_reg),
        .rdata (link_rdata)
    );

    assign res_valid    = res_valid_reg;
    assign result_kind  = kind_reg;
    assign result_entry = entry_reg;
    assign result_owner = owner_reg;
    assign alloc_width  = w_out_reg;
    assign alloc_height = h_out_reg;
    assign last_result  = last_reg;

    a_hand_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hand_reg != '0)
        else $error("clock hand on reserved entry");

    a_commit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (n_reg != '0) && !valid_reg[n_reg])
        else $error("allocation onto reserved or live entry");

    a_free_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_op |-> valid_reg[cur_reg])
        else $error("freeing an entry that is not live");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!res_valid_reg || res_ready))
        else $error("result overwritten while pending");

endmodule

`default_nettype wire

[hw/rtl/scca_ctrl.sv]
// ----------------------------------------------------------------------------
// scca_ctrl
// Request sequencer: dispatch, clock sweeps, table scans and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module scca_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire scca_pkg::dp_stat_t   stat,
    output scca_pkg::dp_cmd_t         cmd
);

    import scca_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_POP      = 4'd2;
    localparam logic [3:0] S_VIS_RD   = 4'd3;
    localparam logic [3:0] S_VIS_EV   = 4'd4;
    localparam logic [3:0] S_SIZE     = 4'd5;
    localparam logic [3:0] S_FIT      = 4'd6;
    localparam logic [3:0] S_ROOM_CHK = 4'd7;
    localparam logic [3:0] S_COMMIT   = 4'd8;
    localparam logic [3:0] S_REL      = 4'd9;
    localparam logic [3:0] S_REL_EV   = 4'd10;
    localparam logic [3:0] S_TOUCH    = 4'd11;
    localparam logic [3:0] S_CLR_RD   = 4'd12;
    localparam logic [3:0] S_CLR_EV   = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              room_reg, room_next;
    logic              step;
    logic              hit;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        kind_next  = kind_reg;
        room_next  = room_reg;
        step       = 1'b0;
        hit        = stat.cur_valid &&
                     ((stat.req_type == REQ_CLEAR_ALL) || stat.tex_match);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.req_type) inside
                    REQ_ALLOC:
                    begin
                        if (stat.frame_over)
                        begin
                            kind_next  = RES_FAIL;
                            state_next = S_EMIT;
                        end
                        else if (stat.fh_nz)
                        begin
                            cmd.link_rd = 1'b1;
                            state_next  = S_POP;
                        end
                        else if (!stat.hw_full)
                        begin
                            cmd.bump   = 1'b1;
                            state_next = S_SIZE;
                        end
                        else
                        begin
                            cmd.cur_op  = CUR_HAND;
                            cmd.cnt_clr = 1'b1;
                            room_next   = 1'b0;
                            state_next  = S_VIS_RD;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (stat.idx_zero)
                        begin
                            kind_next  = RES_ERROR;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.cur_op = CUR_IDX;
                            state_next = S_REL;
                        end
                    end
                    REQ_CLEAR_ALL, REQ_CLEAR_TEX:
                    begin
                        cmd.cur_op = CUR_ONE;
                        state_next = S_CLR_RD;
                    end
                    REQ_TOUCH:
                    begin
                        cmd.cur_op = CUR_IDX;
                        state_next = S_TOUCH;
                    end
                    REQ_NEW_FRAME:
                    begin
                        cmd.frame_clr = 1'b1;
                        kind_next     = RES_DONE;
                        state_next    = S_EMIT;
                    end
                    default:
                    begin
                        kind_next  = RES_DONE;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_SIZE;
            end
            S_VIS_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_VIS_EV;
            end
            S_VIS_EV:
            begin
                if (!stat.cur_valid)
                begin
                    step = 1'b1;
                end
                else if (!stat.age_zero)
                begin
                    cmd.age_dec = 1'b1;
                    step        = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = RES_EVICT;
                    cmd.free_op = 1'b1;
                    if (room_reg)
                    begin
                        cmd.push = 1'b1;
                        step     = 1'b1;
                    end
                    else
                    begin
                        cmd.take_cur = 1'b1;
                        state_next   = S_SIZE;
                    end
                end
                if (step)
                begin
                    cmd.hand_adv = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (stat.cnt_last)
                    begin
                        if (room_reg)
                        begin
                            state_next = S_COMMIT;
                        end
                        else
                        begin
                            kind_next  = RES_FAIL;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        state_next = room_reg ? S_ROOM_CHK : S_VIS_RD;
                    end
                end
            end
            S_SIZE:
            begin
                cmd.calc_size = 1'b1;
                state_next    = S_FIT;
            end
            S_FIT:
            begin
                if (stat.fit_over)
                begin
                    cmd.cur_op  = CUR_HAND;
                    cmd.cnt_clr = 1'b1;
                    room_next   = 1'b1;
                    state_next  = S_VIS_RD;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_ROOM_CHK:
            begin
                state_next = stat.fit_ge ? S_VIS_RD : S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.kind   = RES_ALLOC_OK;
                    state_next = S_IDLE;
                end
            end
            S_REL:
            begin
                kind_next = RES_DONE;
                if (stat.idx_in_range && stat.cur_valid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_REL_EV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_REL_EV:
            begin
                cmd.free_op = 1'b1;
                cmd.push    = 1'b1;
                state_next  = S_EMIT;
            end
            S_TOUCH:
            begin
                cmd.age_touch = stat.idx_in_range && stat.cur_valid;
                kind_next     = RES_DONE;
                state_next    = S_EMIT;
            end
            S_CLR_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CLR_EV;
            end
            S_CLR_EV:
            begin
                if (!hit || stat.out_free)
                begin
                    if (hit)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.kind    = RES_EVICT;
                        cmd.free_op = 1'b1;
                        cmd.push    = 1'b1;
                    end
                    if (stat.cur_last)
                    begin
                        kind_next  = RES_DONE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.cur_inc = 1'b1;
                        state_next  = S_CLR_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = kind_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_DONE;
            room_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            room_reg  <= room_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/surface_cache_clock_allocator_core.sv]
// ----------------------------------------------------------------------------
// surface_cache_clock_allocator_core
// Surface cache id allocator with free list, clock replacement and budgets.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    type, size, owner, texture, entry
//   res      out  res.valid/ready    kind, entry, owner, size, last
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// One request at a time. Alloc sweeps the clock hand over the entries (read,
// evaluate) while looking for a free id, and (read, evaluate, room check)
// while making room. Clear all / clear texture read each entry from the table
// RAM, then evaluate it.
// A result waits in the output register; the sequencer stalls on it.
// No clearing pass after reset; requests are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module surface_cache_clock_allocator_core #(
    parameter int ENTRIES = scca_pkg::DEF_ENTRIES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    scca_req_if.sink                        req,
    scca_res_if.source                      res,
    input  wire logic                       cfg_we,
    input  wire logic [scca_pkg::CFG_W-1:0] cfg_index,
    input  wire logic [scca_pkg::MEM_W-1:0] cfg_data
);

    import scca_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    scca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scca_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req.req_type),
        .surf_width   (req.surf_width),
        .surf_height  (req.surf_height),
        .owner_handle (req.owner_handle),
        .texture_tag  (req.texture_tag),
        .entry_index  (req.entry_index),
        .cmd          (cmd),
        .stat         (stat),
        .res_valid    (res.valid),
        .res_ready    (res.ready),
        .result_kind  (res.result_kind),
        .result_entry (res.result_entry),
        .result_owner (res.result_owner),
        .alloc_width  (res.alloc_width),
        .alloc_height (res.alloc_height),
        .last_result  (res.last_result)
    );

endmodule

`default_nettype wire

[verif/tb_surface_cache_clock_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_surface_cache_clock_allocator_core
// Drives request transactions into the surface cache allocator and predicts
// every result: id selection from the free list and the high-water mark,
// size padding and rounding, clock sweeps, evictions and the memory budgets.
// Each result transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_surface_cache_clock_allocator_core;
    import scca_pkg::*;

    localparam int NUM_ENTRIES = DEF_ENTRIES;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic [OWNER_W-1:0] owner;
        logic [TEX_W-1:0]   tex;
        logic [IDX_W-1:0]   idx;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   entry;
        logic [OWNER_W-1:0] owner;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic               last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_index;
    logic [MEM_W-1:0] cfg_data;

    scca_req_if req ();
    scca_res_if res ();

    surface_cache_clock_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    request_t pending_reqs[$];
    result_t  expected_results[$];
    int errors = 0;
    int src_idle = 0;
    int snk_idle = 0;
    int quiet_cycles = 0;
    int outstanding = 0;

    int unsigned capacity, frame_limit, round_mode;
    bit          valid_tbl[NUM_ENTRIES];
    int unsigned width_tbl[NUM_ENTRIES], height_tbl[NUM_ENTRIES];
    int unsigned age_tbl[NUM_ENTRIES], tex_tbl[NUM_ENTRIES];
    int unsigned owner_tbl[NUM_ENTRIES], link_tbl[NUM_ENTRIES];
    int unsigned free_head, high_water, used_mem, frame_mem, hand;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_result(int unsigned kind, int unsigned ent, int unsigned own,
                               int unsigned w, int unsigned h, bit last);
        result_t r;
        r.kind = kind[KIND_W-1:0];
        r.entry = ent[IDX_W-1:0];
        r.owner = own[OWNER_W-1:0];
        r.w = w[DIM_W-1:0];
        r.h = h[DIM_W-1:0];
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic take_id(output int unsigned n);
        if (free_head != 0) begin
            n = free_head;
            free_head = link_tbl[n];
        end
        else if (high_water >= NUM_ENTRIES - 1) begin
            n = 0;
        end
        else begin
            high_water++;
            n = high_water;
        end
    endtask

    task automatic free_entry(int unsigned n);
        int unsigned sz;
        sz = width_tbl[n] * height_tbl[n];
        used_mem = (used_mem > sz) ? used_mem - sz : 0;
        valid_tbl[n] = 1'b0;
        link_tbl[n] = free_head;
        free_head = n;
    endtask

    task automatic evict_entry(int unsigned n);
        push_result(RES_EVICT, n, owner_tbl[n], 0, 0, 1'b0);
        free_entry(n);
    endtask

    task automatic hand_step(output bit evicted);
        evicted = 1'b0;
        if (hand == 0 || hand >= NUM_ENTRIES) hand = 1;
        if (valid_tbl[hand]) begin
            if (age_tbl[hand] != 0) begin
                age_tbl[hand]--;
            end
            else begin
                evict_entry(hand);
                evicted = 1'b1;
            end
        end
    endtask

    task automatic advance_hand();
        hand++;
        if (hand >= NUM_ENTRIES) hand = 1;
    endtask

    function automatic int unsigned pow2_up(int unsigned v);
        for (int unsigned i = 8; i < 512; i += i)
            if (i >= v) return i;
        return v;
    endfunction

    task automatic predict_alloc(request_t r);
        int unsigned x, y, n, sz, cnt;
        bit ev, found;
        x = r.w + 4;
        y = r.h + 4;
        if (frame_mem > frame_limit) begin
            push_result(RES_FAIL, 0, 0, 0, 0, 1'b1);
            return;
        end
        take_id(n);
        if (n == 0) begin
            cnt = 0;
            forever begin
                hand_step(ev);
                if (ev) break;
                advance_hand();
                cnt++;
                if (cnt > 2 * NUM_ENTRIES) break;
            end
            take_id(n);
            if (n == 0) begin
                push_result(RES_FAIL, 0, 0, 0, 0, 1'b1);
                return;
            end
        end
        if (round_mode != 0) begin
            if (y > 8) begin
                found = 1'b0;
                for (int i = 2; i < 9 && !found; i++) begin
                    if ((2 << i) >= y) begin
                        y = 2 << i;
                        found = 1'b1;
                    end
                    else if ((3 << i) >= y) begin
                        y = 3 << i;
                        found = 1'b1;
                    end
                end
            end
        end
        else begin
            y = pow2_up(y);
            x = pow2_up(x);
        end
        sz = x * y;
        if (sz + used_mem > capacity) begin
            cnt = 0;
            while (sz + used_mem >= capacity) begin
                hand_step(ev);
                advance_hand();
                cnt++;
                if (cnt > 2 * NUM_ENTRIES) break;
            end
        end
        used_mem += sz;
        if (used_mem > MEM_MAX) used_mem = MEM_MAX;
        frame_mem += sz;
        if (frame_mem > MEM_MAX) frame_mem = MEM_MAX;
        valid_tbl[n] = 1'b1;
        width_tbl[n] = x & 511;
        height_tbl[n] = y & 511;
        owner_tbl[n] = r.owner;
        tex_tbl[n] = r.tex;
        age_tbl[n] = (frame_mem < frame_limit) ? 3 : 2;
        push_result(RES_ALLOC_OK, n, 0, x, y, 1'b1);
    endtask

    task automatic predict_request(request_t r);
        case (r.kind)
            REQ_ALLOC:
            begin
                predict_alloc(r);
                return;
            end
            REQ_RELEASE:
            begin
                if (r.idx == 0) begin
                    push_result(RES_ERROR, 0, 0, 0, 0, 1'b1);
                    return;
                end
                if (valid_tbl[r.idx]) free_entry(r.idx);
            end
            REQ_CLEAR_ALL:
                for (int i = 1; i < NUM_ENTRIES; i++)
                    if (valid_tbl[i]) evict_entry(i);
            REQ_CLEAR_TEX:
                for (int i = 1; i < NUM_ENTRIES; i++)
                    if (valid_tbl[i] && tex_tbl[i] == r.tex) evict_entry(i);
            REQ_TOUCH:
                if (r.idx != 0 && valid_tbl[r.idx]) age_tbl[r.idx] = 1;
            REQ_NEW_FRAME:
                frame_mem = 0;
            default: ;
        endcase
        push_result(RES_DONE, 0, 0, 0, 0, 1'b1);
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("%0t: result %s mismatch: got %0d, expected %0d", $realtime, field,
                 got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req.valid <= 1'b0;
        end
        else if (!req.valid || req.ready) begin : drive
            request_t r;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
                r = pending_reqs.pop_front();
                req.valid <= 1'b1;
                req.req_type <= r.kind;
                req.surf_width <= r.w;
                req.surf_height <= r.h;
                req.owner_handle <= r.owner;
                req.texture_tag <= r.tex;
                req.entry_index <= r.idx;
            end
            else begin
                req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) res.ready <= 1'b0;
        else res.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin : observe
            result_t want;
            request_t r;
            quiet_cycles++;
            if (res.valid && res.ready) begin
                quiet_cycles = 0;
                if (res.last_result === 1'b1 && outstanding > 0) outstanding--;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, kind %0d", $realtime,
                             res.result_kind);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (res.result_kind !== want.kind)
                        report_mismatch("kind", res.result_kind, want.kind);
                    if (res.result_entry !== want.entry)
                        report_mismatch("entry", res.result_entry, want.entry);
                    if (res.result_owner !== want.owner)
                        report_mismatch("owner", res.result_owner, want.owner);
                    if (res.alloc_width !== want.w)
                        report_mismatch("width", res.alloc_width, want.w);
                    if (res.alloc_height !== want.h)
                        report_mismatch("height", res.alloc_height, want.h);
                    if (res.last_result !== want.last)
                        report_mismatch("last", res.last_result, want.last);
                end
            end
            if (req.valid && req.ready) begin
                quiet_cycles = 0;
                outstanding++;
                r.kind = req.req_type;
                r.w = req.surf_width;
                r.h = req.surf_height;
                r.owner = req.owner_handle;
                r.tex = req.texture_tag;
                r.idx = req.entry_index;
                predict_request(r);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_surface_cache_clock_allocator_core failed");
                $finish;
            end
        end
    end

    function automatic request_t make_req(logic [REQ_W-1:0] kind, int unsigned w,
                                          int unsigned h, int unsigned owner,
                                          int unsigned tex, int unsigned idx);
        request_t r;
        r.kind = kind;
        r.w = w[SIDE_W-1:0];
        r.h = h[SIDE_W-1:0];
        r.owner = owner[OWNER_W-1:0];
        r.tex = tex[TEX_W-1:0];
        r.idx = idx[IDX_W-1:0];
        return r;
    endfunction

    function automatic request_t random_req(int alloc_pct);
        int unsigned pick, side_max, idx;
        logic [REQ_W-1:0] kind;
        pick = $urandom_range(99);
        if (pick < alloc_pct) kind = REQ_ALLOC;
        else if (pick < alloc_pct + (100 - alloc_pct) * 30 / 100) kind = REQ_RELEASE;
        else if (pick < alloc_pct + (100 - alloc_pct) * 55 / 100) kind = REQ_TOUCH;
        else if (pick < alloc_pct + (100 - alloc_pct) * 72 / 100) kind = REQ_CLEAR_TEX;
        else if (pick < alloc_pct + (100 - alloc_pct) * 85 / 100) kind = REQ_NEW_FRAME;
        else if (pick < alloc_pct + (100 - alloc_pct) * 92 / 100) kind = REQ_CLEAR_ALL;
        else kind = REQ_ALLOC | REQ_W'($urandom_range(6, 7));
        side_max = ($urandom_range(9) == 0) ? 240 : 60;
        idx = ($urandom_range(9) == 0) ? $urandom_range(63)
                                         : $urandom_range(high_water + 1);
        return make_req(kind, $urandom_range(side_max), $urandom_range(side_max),
                        $urandom_range(65535), $urandom_range(7) | ($urandom_range(1) << 7)
                        | ($urandom_range(9) == 0 ? $urandom_range(255) : 0), idx);
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || req.valid || outstanding > 0 ||
               expected_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] index, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[MEM_W-1:0];
        case (index)
            CFG_CAPACITY: capacity = value & MEM_MAX;
            CFG_LIMIT:    frame_limit = value & MEM_MAX;
            default:      round_mode = value & 1;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, int alloc_pct);
        for (int i = 0; i < count; i++) begin
            pending_reqs.push_back(random_req(alloc_pct));
            while (pending_reqs.size() > 0) @(posedge clk);
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.surf_width = '0;
        req.surf_height = '0;
        req.owner_handle = '0;
        req.texture_tag = '0;
        req.entry_index = '0;
        res.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        capacity = CAP_RESET;
        frame_limit = LIMIT_RESET;
        round_mode = 1;
        free_head = 0;
        high_water = 0;
        used_mem = 0;
        frame_mem = 0;
        hand = 1;
        foreach (valid_tbl[i]) valid_tbl[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 11;
        snk_idle = 58;
        pending_reqs.push_back(make_req(REQ_ALLOC, 0, 0, 16'h0001, 8'h01, 0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 240, 240, 16'hFFFF, 8'hFF, 0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 15, 5, 16'h1234, 8'h01, 0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 4, 4, 16'h8000, 8'h80, 0));
        pending_reqs.push_back(make_req(REQ_RELEASE, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_RELEASE, 0, 0, 0, 0, 2));
        pending_reqs.push_back(make_req(REQ_RELEASE, 0, 0, 0, 0, 63));
        pending_reqs.push_back(make_req(REQ_RELEASE, 0, 0, 0, 0, 2));
        pending_reqs.push_back(make_req(REQ_ALLOC, 100, 200, 16'h00AA, 8'h7F, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, 0, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(REQ_TOUCH, 0, 0, 0, 0, 50));
        pending_reqs.push_back(make_req(REQ_CLEAR_TEX, 0, 0, 0, 8'h01, 0));
        pending_reqs.push_back(make_req(REQ_NEW_FRAME, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd6, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 255, 255, 16'hFFFF, 8'hFF, 63));
        pending_reqs.push_back(make_req(REQ_CLEAR_ALL, 0, 0, 0, 0, 0));
        drain();

        configure(CFG_ROUNDING, 0);
        configure(CFG_CAPACITY, 40000);
        configure(CFG_LIMIT, 4194304);
        pending_reqs.push_back(make_req(REQ_ALLOC, 240, 3, 16'h0F0F, 8'h10, 0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 0, 240, 16'hF0F0, 8'h10, 0));
        run_random(40, 55);
        drain();

        src_idle = 58;
        snk_idle = 11;
        configure(CFG_ROUNDING, 1);
        configure(CFG_CAPACITY, 4194304);
        configure(CFG_LIMIT, 60000);
        run_random(45, 50);
        drain();

        src_idle = 0;
        snk_idle = 0;
        configure(CFG_LIMIT, 4194304);
        run_random(45, 85);
        drain();

        configure(CFG_CAPACITY, 0);
        configure(CFG_LIMIT, 0);
        configure(CFG_ROUNDING, 0);
        run_random(15, 50);
        drain();

        configure(CFG_CAPACITY, 8388607);
        configure(CFG_LIMIT, 8388607);
        run_random(15, 60);
        drain();
        repeat (50) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("tb_surface_cache_clock_allocator_core passed");
        else
            $display("tb_surface_cache_clock_allocator_core failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/scca_pkg.sv
hw/rtl/scca_ifs.sv
hw/rtl/scca_ram.sv
hw/rtl/scca_datapath.sv
hw/rtl/scca_ctrl.sv
hw/rtl/surface_cache_clock_allocator_core.sv
verif/tb_surface_cache_clock_allocator_core.sv
